### hdl/ath_pkg.sv
// Shared types and constants for the atan2 Hastings approximation pipeline.
// No dependencies; every other file in hdl/ imports this package.
package ath_pkg;

    // Operand and quotient widths.
    localparam int MAG_W = 16;
    localparam int Q_W   = 16;
    localparam int PROD_W = 32;

    // Divider layout: quotient bits produced per stage, and number of stages.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // Angle offset width; holds up to 3*pi/2 plus sign.
    localparam int BASE_W = 17;

    // Hastings coefficients in unsigned Q0.15.
    localparam logic [MAG_W-1:0] COEF1_Q15 = 16'd32616;
    localparam logic [MAG_W-1:0] COEF2_Q15 = 16'd9459;
    localparam logic [MAG_W-1:0] COEF3_Q15 = 16'd2600;

    // pi scaled by 2^29, rounded.
    localparam logic [31:0] PI_Q29 = 32'd1686629713;

    // Side information that travels alongside the ratio through the pipeline.
    typedef struct packed {
        logic              both_zero;
        logic              term_neg;
        logic [BASE_W-1:0] base;
    } t_side;

    // Q0.15 product with round to nearest.
    function automatic logic [MAG_W-1:0] mul_q15(input logic [MAG_W-1:0] a,
                                                 input logic [MAG_W-1:0] b);
        logic [PROD_W-1:0] prod;
        prod = {16'd0, a} * {16'd0, b} + 32'd16384;
        return prod[30:15];
    endfunction

endpackage

### hdl/ath_front.sv
// Input stage: magnitudes, operand swap, quadrant offset and dividend setup.
// Depends on ath_pkg.
module ath_front #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [15:0]         i_y_in,
    input  logic signed [15:0]         i_x_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ath_pkg::MAG_W-1:0]  o_rem,
    output logic [ath_pkg::MAG_W-1:0]  o_low,
    output logic [ath_pkg::MAG_W-1:0]  o_den,
    output ath_pkg::t_side             o_side
);
    import ath_pkg::*;

    localparam logic [31:0] PI_Q_W =
        (PI_Q29 + (32'd1 << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS);
    localparam logic [31:0] HALF_Q_W =
        (PI_Q29 + (32'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    localparam logic [BASE_W-1:0] PI_Q   = PI_Q_W[BASE_W-1:0];
    localparam logic [BASE_W-1:0] HALF_Q = HALF_Q_W[BASE_W-1:0];

    logic              x_neg, y_neg, swap, neg;
    logic [MAG_W-1:0]  ax, ay, num, den;
    logic [30:0]       dividend;
    logic [BASE_W-1:0] quad_off, swap_off;
    t_side             side;

    logic              r_valid;
    logic [MAG_W-1:0]  r_rem, r_low, r_den;
    t_side             r_side;

    assign x_neg = i_x_in[15];
    assign y_neg = i_y_in[15];

    always_comb begin
        ax   = x_neg ? (~i_x_in + 16'd1) : i_x_in;
        ay   = y_neg ? (~i_y_in + 16'd1) : i_y_in;
        swap = ax < ay;
        num  = swap ? ax : ay;
        den  = swap ? ay : ax;
        neg  = x_neg ^ y_neg;
        // Rounded ratio: (num * 2^15 + den / 2) / den.
        dividend = {num, 15'd0} + {16'd0, den[MAG_W-1:1]};
        if (x_neg) begin
            quad_off = y_neg ? (~PI_Q + 17'd1) : PI_Q;
        end else begin
            quad_off = '0;
        end
        if (swap) begin
            swap_off = neg ? (~HALF_Q + 17'd1) : HALF_Q;
        end else begin
            swap_off = '0;
        end
        side.both_zero = (ax == '0) && (ay == '0);
        side.term_neg  = neg ^ swap;
        side.base      = quad_off + swap_off;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem  <= {1'b0, dividend[30:16]};
            r_low  <= dividend[15:0];
            r_den  <= den;
            r_side <= side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

### hdl/ath_div.sv
// Pipelined restoring divider producing the Q0.15 ratio, several quotient
// bits per stage. Depends on ath_pkg.
module ath_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ath_pkg::MAG_W-1:0] i_rem,
    input  logic [ath_pkg::MAG_W-1:0] i_low,
    input  logic [ath_pkg::MAG_W-1:0] i_den,
    input  ath_pkg::t_side            i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ath_pkg::Q_W-1:0]   o_quot,
    output ath_pkg::t_side            o_side
);
    import ath_pkg::*;

    logic             en      [DIV_STAGES+1];
    logic             r_valid [DIV_STAGES];
    logic [MAG_W-1:0] r_rem   [DIV_STAGES];
    logic [MAG_W-1:0] r_low   [DIV_STAGES];
    logic [MAG_W-1:0] r_den   [DIV_STAGES];
    logic [Q_W-1:0]   r_quot  [DIV_STAGES];
    t_side            r_side  [DIV_STAGES];

    assign en[DIV_STAGES] = i_ready;
    assign o_ready        = en[0];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic             v_in;
        logic [MAG_W-1:0] rem_in, low_in, den_in;
        logic [Q_W-1:0]   quot_in;
        t_side            side_in;
        logic [MAG_W:0]   trial;
        logic [MAG_W-1:0] n_rem, n_low;
        logic [Q_W-1:0]   n_quot;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign den_in  = i_den;
            assign quot_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign rem_in  = r_rem[s-1];
            assign low_in  = r_low[s-1];
            assign den_in  = r_den[s-1];
            assign quot_in = r_quot[s-1];
            assign side_in = r_side[s-1];
        end

        assign en[s] = !r_valid[s] || en[s+1];

        // The partial remainder stays below the divisor, so each trial fits
        // one bit more than the operands.
        always_comb begin
            n_rem  = rem_in;
            n_low  = low_in;
            n_quot = quot_in;
            trial  = '0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial = {n_rem, n_low[MAG_W-1]};
                n_low = {n_low[MAG_W-2:0], 1'b0};
                if (trial >= {1'b0, den_in}) begin
                    n_rem  = MAG_W'(trial - {1'b0, den_in});
                    n_quot = {n_quot[Q_W-2:0], 1'b1};
                end else begin
                    n_rem  = trial[MAG_W-1:0];
                    n_quot = {n_quot[Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (en[s]) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= n_low;
                r_den[s]  <= den_in;
                r_quot[s] <= n_quot;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

### hdl/ath_poly.sv
// Odd powers of the ratio and the three coefficient products, one
// multiplication level per register stage. Depends on ath_pkg.
module ath_poly (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ath_pkg::Q_W-1:0]    i_ratio,
    input  ath_pkg::t_side             i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ath_pkg::PROD_W-1:0] o_term1,
    output logic [ath_pkg::PROD_W-1:0] o_term3,
    output logic [ath_pkg::PROD_W-1:0] o_term5,
    output ath_pkg::t_side             o_side
);
    import ath_pkg::*;

    logic en1, en2, en3, en4;

    // Stage 1: r^2 and c1*r.
    logic              r_v1;
    logic [Q_W-1:0]    r_m1, r_m2_1;
    logic [PROD_W-1:0] r_t1_1;
    t_side             r_side1;
    // Stage 2: r^3.
    logic              r_v2;
    logic [Q_W-1:0]    r_m2_2, r_m3_2;
    logic [PROD_W-1:0] r_t1_2;
    t_side             r_side2;
    // Stage 3: r^5 and c2*r^3.
    logic              r_v3;
    logic [Q_W-1:0]    r_m5_3;
    logic [PROD_W-1:0] r_t1_3, r_t3_3;
    t_side             r_side3;
    // Stage 4: c3*r^5.
    logic              r_v4;
    logic [PROD_W-1:0] r_t1_4, r_t3_4, r_t5_4;
    t_side             r_side4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_m1    <= i_ratio;
            r_m2_1  <= mul_q15(i_ratio, i_ratio);
            r_t1_1  <= {16'd0, COEF1_Q15} * {16'd0, i_ratio};
            r_side1 <= i_side;
        end
        if (en2) begin
            r_m2_2  <= r_m2_1;
            r_m3_2  <= mul_q15(r_m2_1, r_m1);
            r_t1_2  <= r_t1_1;
            r_side2 <= r_side1;
        end
        if (en3) begin
            r_m5_3  <= mul_q15(r_m3_2, r_m2_2);
            r_t3_3  <= {16'd0, COEF2_Q15} * {16'd0, r_m3_2};
            r_t1_3  <= r_t1_2;
            r_side3 <= r_side2;
        end
        if (en4) begin
            r_t5_4  <= {16'd0, COEF3_Q15} * {16'd0, r_m5_3};
            r_t3_4  <= r_t3_3;
            r_t1_4  <= r_t1_3;
            r_side4 <= r_side3;
        end
    end

    assign o_valid = r_v4;
    assign o_term1 = r_t1_4;
    assign o_term3 = r_t3_4;
    assign o_term5 = r_t5_4;
    assign o_side  = r_side4;

endmodule

### hdl/ath_back.sv
// Polynomial sum and rounding, then quadrant offset, saturation and the
// output register. Depends on ath_pkg.
module ath_back #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ath_pkg::PROD_W-1:0] i_term1,
    input  logic [ath_pkg::PROD_W-1:0] i_term3,
    input  logic [ath_pkg::PROD_W-1:0] i_term5,
    input  ath_pkg::t_side             i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [15:0]         o_angle,
    output logic                       o_both_zero
);
    import ath_pkg::*;

    localparam int          SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam logic [31:0] RND   = 32'd1 << (SHIFT - 1);
    localparam int          RES_W = BASE_W + 1;

    logic                     en1, en2;
    logic [PROD_W-1:0]        acc, rounded;
    logic signed [RES_W-1:0]  term, res;
    logic signed [15:0]       sat;

    logic                     r_v1;
    logic [BASE_W-1:0]        r_mag;
    t_side                    r_side1;
    logic                     r_v2;
    logic signed [15:0]       r_angle;
    logic                     r_both_zero;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // The sum is never negative and stays below 2^31.
    assign acc     = i_term1 + i_term5 - i_term3;
    assign rounded = (acc + RND) >> SHIFT;

    always_comb begin
        term = $signed({1'b0, r_mag});
        if (r_side1.term_neg) begin
            term = -term;
        end
        res = $signed({r_side1.base[BASE_W-1], r_side1.base}) + term;
        if (res > $signed(RES_W'(32767))) begin
            sat = 16'sh7fff;
        end else if (res < -$signed(RES_W'(32768))) begin
            sat = 16'sh8000;
        end else begin
            sat = res[15:0];
        end
        if (r_side1.both_zero) begin
            sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mag   <= rounded[BASE_W-1:0];
            r_side1 <= i_side;
        end
        if (en2) begin
            r_angle     <= sat;
            r_both_zero <= r_side1.both_zero;
        end
    end

    assign o_valid     = r_v2;
    assign o_angle     = r_angle;
    assign o_both_zero = r_both_zero;

endmodule

### hdl/atan2_hastings_approx.sv
// Four-quadrant atan2 using the Hastings odd polynomial, fully pipelined.
// Instantiates ath_front, ath_div, ath_poly and ath_back; depends on ath_pkg.
//
// The block takes a request of a signed 16-bit pair (i_y_in, i_x_in) on a
// valid/ready channel and returns the angle atan2(y, x) in radians as a
// signed fixed-point value with ANGLE_FRAC_BITS fraction bits (Q3.13 by
// default), plus o_both_zero, which is set when both inputs are zero and the
// angle is then forced to zero. Results leave on a second valid/ready channel
// in the order the requests arrived.
//
// An accepted request passes through 11 register stages: one input stage, four
// divider stages (four quotient bits each), four multiplier stages and two
// output stages. Throughput is one request per cycle while the receiver keeps
// i_ready high.
//
// Every stage carries its own valid bit and advances when it is empty or when
// the stage after it advances. When the receiver holds i_ready low, the
// finished result waits in the output register while empty stages upstream
// keep filling, so o_ready stays high until the whole pipeline is full.
// Reset is synchronous and active low; it clears all valid bits, so the block
// comes out of reset empty and ready.
module atan2_hastings_approx #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_y_in,
    input  logic signed [15:0] i_x_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_angle,
    output logic               o_both_zero
);
    import ath_pkg::*;

    // Front end to divider.
    logic             fd_valid, fd_ready;
    logic [MAG_W-1:0] fd_rem, fd_low, fd_den;
    t_side            fd_side;

    // Divider to polynomial stages.
    logic             dp_valid, dp_ready;
    logic [Q_W-1:0]   dp_ratio;
    t_side            dp_side;

    // Polynomial stages to back end.
    logic              pb_valid, pb_ready;
    logic [PROD_W-1:0] pb_term1, pb_term3, pb_term5;
    t_side             pb_side;

    ath_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_y_in  (i_y_in),
        .i_x_in  (i_x_in),
        .o_valid (fd_valid),
        .i_ready (fd_ready),
        .o_rem   (fd_rem),
        .o_low   (fd_low),
        .o_den   (fd_den),
        .o_side  (fd_side)
    );

    // The ratio is rounded to nearest and never exceeds 1.0 in Q0.15 unless both inputs are zero.
    ath_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fd_valid),
        .o_ready (fd_ready),
        .i_rem   (fd_rem),
        .i_low   (fd_low),
        .i_den   (fd_den),
        .i_side  (fd_side),
        .o_valid (dp_valid),
        .i_ready (dp_ready),
        .o_quot  (dp_ratio),
        .o_side  (dp_side)
    );

    ath_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dp_valid),
        .o_ready (dp_ready),
        .i_ratio (dp_ratio),
        .i_side  (dp_side),
        .o_valid (pb_valid),
        .i_ready (pb_ready),
        .o_term1 (pb_term1),
        .o_term3 (pb_term3),
        .o_term5 (pb_term5),
        .o_side  (pb_side)
    );

    ath_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pb_valid),
        .o_ready     (pb_ready),
        .i_term1     (pb_term1),
        .i_term3     (pb_term3),
        .i_term5     (pb_term5),
        .i_side      (pb_side),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_angle     (o_angle),
        .o_both_zero (o_both_zero)
    );

endmodule
